// ===== src/rhsv_pkg.sv =====
`default_nettype none
package rhsv_pkg;

	localparam int CHAN_W = 8;
	localparam int OUT_W  = 15;
	localparam int QUO_W  = 15;
	localparam int NUM_W  = CHAN_W + QUO_W;

	localparam logic [OUT_W-1:0] HUE_RED   = 15'd0;
	localparam logic [OUT_W-1:0] HUE_GREEN = 15'd7680;
	localparam logic [OUT_W-1:0] HUE_BLUE  = 15'd15360;
	localparam logic [OUT_W-1:0] HUE_WRAP  = 15'd23040;

	// one restoring-division lane: partial remainder, shift register
	// (numerator bits out at the top, quotient bits in at the bottom), divisor
	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [QUO_W-1:0]  sh;
		logic [CHAN_W-1:0] den;
	} div_lane_t;

	typedef struct packed {
		div_lane_t sat;
		div_lane_t hue;
	} div_pair_t;

	typedef struct packed {
		logic [OUT_W-1:0] brightness;
		logic             grey;
		logic             neg;
		logic [OUT_W-1:0] hue_off;
	} pix_side_t;

	function automatic div_lane_t div_init(input logic [NUM_W-1:0] num,
			input logic [CHAN_W-1:0] den);
		div_lane_t r;
		r.rem = num[NUM_W-1:QUO_W];
		r.sh  = num[QUO_W-1:0];
		r.den = den;
		return r;
	endfunction

	function automatic div_lane_t div_step(input div_lane_t a);
		div_lane_t         r;
		logic [CHAN_W:0]   t;
		logic [CHAN_W:0]   dif;
		t   = {a.rem, a.sh[QUO_W-1]};
		dif = t - {1'b0, a.den};
		r.den = a.den;
		if (t >= {1'b0, a.den}) begin
			r.rem = dif[CHAN_W-1:0];
			r.sh  = {a.sh[QUO_W-2:0], 1'b1};
		end else begin
			r.rem = t[CHAN_W-1:0];
			r.sh  = {a.sh[QUO_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/rhsv_front.sv =====
`default_nettype none
module rhsv_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [rhsv_pkg::CHAN_W-1:0]   red,
	input  wire logic [rhsv_pkg::CHAN_W-1:0]   green,
	input  wire logic [rhsv_pkg::CHAN_W-1:0]   blue,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output rhsv_pkg::div_pair_t                out_op,
	output rhsv_pkg::pix_side_t                out_side
);

	localparam int CW = rhsv_pkg::CHAN_W;
	localparam int OW = rhsv_pkg::OUT_W;

	logic [CW-1:0] mx, mn, d, absd;
	logic [CW:0]   diff;
	logic          blue_max, green_max, neg;
	logic [OW-1:0] hue_off;

	logic          v_s1, v_s2, rdy1, rdy2;
	logic [CW-1:0] mx_s1, d_s1, absd_s1;
	logic          neg_s1;
	logic [OW-1:0] off_s1;

	logic [OW-1:0]               d100, y, bright;
	logic [11:0]                 abs15;
	logic [OW:0]                 frac;
	logic [rhsv_pkg::NUM_W-1:0]  sat_num, hue_num;
	rhsv_pkg::div_pair_t         op_s2;
	rhsv_pkg::pix_side_t         side_s2;

	always_comb begin
		mx = (red > green) ? red : green;
		mx = (mx > blue) ? mx : blue;
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		d  = mx - mn;
		blue_max  = (blue == mx);
		green_max = (green == mx);
		if (blue_max) begin
			diff = {1'b0, red} - {1'b0, green};
		end else if (green_max) begin
			diff = {1'b0, blue} - {1'b0, red};
		end else begin
			diff = {1'b0, green} - {1'b0, blue};
		end
		neg  = diff[CW];
		absd = neg ? CW'(-diff) : diff[CW-1:0];
		if (blue_max) begin
			hue_off = rhsv_pkg::HUE_BLUE;
		end else if (green_max) begin
			hue_off = rhsv_pkg::HUE_GREEN;
		end else if (neg) begin
			hue_off = rhsv_pkg::HUE_WRAP;
		end else begin
			hue_off = rhsv_pkg::HUE_RED;
		end
	end

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			mx_s1   <= mx;
			d_s1    <= d;
			absd_s1 <= absd;
			neg_s1  <= neg;
			off_s1  <= hue_off;
		end
	end

	// value = 100*mx + floor(100*mx/255), the /255 done as (y + y/256 + 1)/256
	always_comb begin
		d100    = OW'(d_s1) * 15'd100;
		abs15   = 12'(absd_s1) * 12'd15;
		y       = OW'(mx_s1) * 15'd100;
		frac    = ((OW+1)'(y) + (OW+1)'(y >> 8) + 16'd1) >> 8;
		bright  = y + frac[OW-1:0];
		sat_num = {d100, 8'b0};
		hue_num = {3'b0, abs15, 8'b0};
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			op_s2.sat          <= rhsv_pkg::div_init(sat_num, mx_s1);
			op_s2.hue          <= rhsv_pkg::div_init(hue_num, d_s1);
			side_s2.brightness <= bright;
			side_s2.grey       <= (d_s1 == '0);
			side_s2.neg        <= neg_s1;
			side_s2.hue_off    <= off_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_op    = op_s2;
	assign out_side  = side_s2;

endmodule
`default_nettype wire

// ===== src/rhsv_div.sv =====
`default_nettype none
module rhsv_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire rhsv_pkg::div_pair_t  in_op,
	input  wire rhsv_pkg::pix_side_t  in_side,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output rhsv_pkg::div_pair_t       out_res,
	output rhsv_pkg::pix_side_t       out_side
);

	localparam int Q = rhsv_pkg::QUO_W;

	logic [Q-1:0]         vld_s;
	logic [Q:0]           rdy;
	rhsv_pkg::div_pair_t  st_s   [Q];
	rhsv_pkg::pix_side_t  side_s [Q];

	assign rdy[Q] = out_ready;

	// one quotient bit per stage for both lanes
	for (genvar i = 0; i < Q; i++) begin : g_stage
		rhsv_pkg::div_pair_t src;
		rhsv_pkg::pix_side_t src_side;
		logic                src_v;

		if (i == 0) begin : g_first
			assign src      = in_op;
			assign src_side = in_side;
			assign src_v    = in_valid;
		end else begin : g_next
			assign src      = st_s[i-1];
			assign src_side = side_s[i-1];
			assign src_v    = vld_s[i-1];
		end

		assign rdy[i] = !vld_s[i] || rdy[i+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (rdy[i]) begin
				vld_s[i] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && src_v) begin
				st_s[i].sat <= rhsv_pkg::div_step(src.sat);
				st_s[i].hue <= rhsv_pkg::div_step(src.hue);
				side_s[i]   <= src_side;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[Q-1];
	assign out_res   = st_s[Q-1];
	assign out_side  = side_s[Q-1];

endmodule
`default_nettype wire

// ===== src/rhsv_post.sv =====
`default_nettype none
module rhsv_post (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rhsv_pkg::div_pair_t         in_res,
	input  wire rhsv_pkg::pix_side_t         in_side,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [rhsv_pkg::OUT_W-1:0]       hue,
	output logic [rhsv_pkg::OUT_W-1:0]       saturation,
	output logic [rhsv_pkg::OUT_W-1:0]       brightness
);

	localparam int OW = rhsv_pkg::OUT_W;

	logic          v_s18, rdy;
	logic [OW-1:0] hue_s18, sat_s18, bright_s18;
	logic [OW-1:0] hue_nxt, sat_nxt;
	logic          rem_nz;

	// negative offset from the sector base rounds down: subtract one more
	// when the division left a remainder
	always_comb begin
		rem_nz = |in_res.hue.rem;
		if (in_side.grey) begin
			hue_nxt = '0;
			sat_nxt = '0;
		end else begin
			sat_nxt = in_res.sat.sh;
			if (in_side.neg) begin
				hue_nxt = in_side.hue_off - in_res.hue.sh - OW'(rem_nz);
			end else begin
				hue_nxt = in_side.hue_off + in_res.hue.sh;
			end
		end
	end

	assign rdy      = !v_s18 || out_ready;
	assign in_ready = rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s18 <= 1'b0;
		end else if (rdy) begin
			v_s18 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) begin
			hue_s18    <= hue_nxt;
			sat_s18    <= sat_nxt;
			bright_s18 <= in_side.brightness;
		end
	end

	assign out_valid  = v_s18;
	assign hue        = hue_s18;
	assign saturation = sat_s18;
	assign brightness = bright_s18;

endmodule
`default_nettype wire

// ===== src/rgb_to_hsv_pixel_unit.sv =====
`default_nettype none
// RGB to HSV converter, one pixel request per clock while pixel_ready is high. There
// are 18 register stages: two front stages (max/min, sector select, scaling
// multiplies), fifteen divider stages that each resolve one quotient bit for the
// saturation and hue divisions, and one output stage. Every stage has its own
// valid bit and ready, so bubbles close up and a stalled output only backs up as
// far as needed. hue is degrees * 64, saturation and brightness are
// percent * 256; a grey pixel gives hue and saturation of zero.
module rgb_to_hsv_pixel_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pixel_valid,
	output logic                             pixel_ready,
	input  wire logic [rhsv_pkg::CHAN_W-1:0] red,
	input  wire logic [rhsv_pkg::CHAN_W-1:0] green,
	input  wire logic [rhsv_pkg::CHAN_W-1:0] blue,
	output logic                             hsv_valid,
	input  wire logic                        hsv_ready,
	output logic [rhsv_pkg::OUT_W-1:0]       hue,
	output logic [rhsv_pkg::OUT_W-1:0]       saturation,
	output logic [rhsv_pkg::OUT_W-1:0]       brightness
);

	logic                f_valid, f_ready, d_valid, d_ready;
	rhsv_pkg::div_pair_t f_op, d_res;
	rhsv_pkg::pix_side_t f_side, d_side;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel_valid),
		.in_ready  (pixel_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_op    (f_op),
		.out_side  (f_side)
	);

	rhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_op     (f_op),
		.in_side   (f_side),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_res   (d_res),
		.out_side  (d_side)
	);

	rhsv_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (d_valid),
		.in_ready   (d_ready),
		.in_res     (d_res),
		.in_side    (d_side),
		.out_valid  (hsv_valid),
		.out_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule
`default_nettype wire

// ===== tb/rgb_to_hsv_pixel_checker.sv =====
module rgb_to_hsv_pixel_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pixel_valid,
	input  logic                        pixel_ready,
	input  logic [rhsv_pkg::CHAN_W-1:0] red,
	input  logic [rhsv_pkg::CHAN_W-1:0] green,
	input  logic [rhsv_pkg::CHAN_W-1:0] blue,
	input  logic                        hsv_valid,
	input  logic                        hsv_ready,
	input  logic [rhsv_pkg::OUT_W-1:0]  hue,
	input  logic [rhsv_pkg::OUT_W-1:0]  saturation,
	input  logic [rhsv_pkg::OUT_W-1:0]  brightness,
	output int                          mismatches,
	output int                          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SECTOR      = 3840;
	localparam int FULL_CIRCLE = 23040;
	localparam int PCT_SCALE   = 25600;
	localparam int CHAN_MAX    = 255;
	localparam int SECT_RED    = 0;
	localparam int SECT_GREEN  = 2;
	localparam int SECT_BLUE   = 4;
	localparam int SHOW_MAX    = 10;

	typedef struct packed {
		logic [rhsv_pkg::OUT_W-1:0] hue;
		logic [rhsv_pkg::OUT_W-1:0] sat;
		logic [rhsv_pkg::OUT_W-1:0] bright;
	} hsv_t;

	hsv_t hsv_due[$];
	hsv_t want;
	hsv_t seen;
	int   errs = 0;
	int   n_results = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic hsv_t hsv_of_pixel(input logic [rhsv_pkg::CHAN_W-1:0] r,
			input logic [rhsv_pkg::CHAN_W-1:0] g, input logic [rhsv_pkg::CHAN_W-1:0] b);
		int   mx;
		int   mn;
		int   d;
		int   base;
		int   diff;
		int   num;
		hsv_t o;
		mx = int'(r);
		if (int'(g) > mx) mx = int'(g);
		if (int'(b) > mx) mx = int'(b);
		mn = int'(r);
		if (int'(g) < mn) mn = int'(g);
		if (int'(b) < mn) mn = int'(b);
		d = mx - mn;
		o.bright = rhsv_pkg::OUT_W'(mx * PCT_SCALE / CHAN_MAX);
		o.sat = '0;
		o.hue = '0;
		if (d > 0) begin
			o.sat = rhsv_pkg::OUT_W'(d * PCT_SCALE / mx);
			// blue wins ties, then green
			if (int'(b) == mx) begin
				base = SECT_BLUE;
				diff = int'(r) - int'(g);
			end else if (int'(g) == mx) begin
				base = SECT_GREEN;
				diff = int'(b) - int'(r);
			end else begin
				base = SECT_RED;
				diff = int'(g) - int'(b);
			end
			num = base * SECTOR * d + diff * SECTOR;
			if (num < 0)
				num += FULL_CIRCLE * d;
			o.hue = rhsv_pkg::OUT_W'(num / d);
		end
		return o;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (hsv_valid && hsv_ready) begin
				seen = '{hue: hue, sat: saturation, bright: brightness};
				if (hsv_due.size() == 0) begin
					errs++;
					if (errs <= SHOW_MAX)
						$display("result %0d: unexpected, got hue %0d sat %0d bright %0d",
							n_results, seen.hue, seen.sat, seen.bright);
				end else begin
					want = hsv_due.pop_front();
					if (want != seen) begin
						errs++;
						if (errs <= SHOW_MAX) begin
							$write("result %0d: expected hue %0d sat %0d bright %0d,",
								n_results, want.hue, want.sat, want.bright);
							$display(" got hue %0d sat %0d bright %0d",
								seen.hue, seen.sat, seen.bright);
						end
					end
				end
				n_results++;
			end
			if (pixel_valid && pixel_ready)
				hsv_due.push_back(hsv_of_pixel(red, green, blue));
		end
		mismatches <= errs;
		outstanding <= hsv_due.size();
	end

endmodule

// ===== tb/tb_rgb_to_hsv_pixel_unit.sv =====
module tb_rgb_to_hsv_pixel_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM   = 1130;
	localparam int MAX_GAP    = 16;
	localparam int LONG_HOLD  = 400;
	localparam int HOLD_AT    = 200;
	localparam int DRAIN      = 40;
	localparam int LIMIT      = 400000;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        pixel_valid = 1'b0;
	logic                        pixel_ready;
	logic [rhsv_pkg::CHAN_W-1:0] red = '0;
	logic [rhsv_pkg::CHAN_W-1:0] green = '0;
	logic [rhsv_pkg::CHAN_W-1:0] blue = '0;
	logic                        hsv_valid;
	logic                        hsv_ready = 1'b0;
	logic [rhsv_pkg::OUT_W-1:0]  hue;
	logic [rhsv_pkg::OUT_W-1:0]  saturation;
	logic [rhsv_pkg::OUT_W-1:0]  brightness;
	int                          mismatches;
	int                          outstanding;
	int                          cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rgb_to_hsv_pixel_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	rgb_to_hsv_pixel_checker hsv_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixel_valid(pixel_valid),
		.pixel_ready(pixel_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.hsv_valid  (hsv_valid),
		.hsv_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	function automatic logic [23:0] rand_pixel();
		logic [7:0] c[3];
		int         sel;
		int         top;
		int         which;
		sel = $urandom_range(0, 9);
		case (sel)
			0: begin
				c[0] = 8'($urandom_range(0, 255));
				c[1] = c[0];
				c[2] = c[0];
			end
			1: begin
				// at least two channels tie for max
				top = $urandom_range(1, 255);
				which = $urandom_range(0, 2);
				foreach (c[k])
					c[k] = 8'(top);
				c[which] = 8'($urandom_range(0, top));
			end
			2: begin
				foreach (c[k])
					c[k] = 8'($urandom_range(0, 3));
			end
			3: begin
				foreach (c[k])
					c[k] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			end
			default: begin
				foreach (c[k])
					c[k] = 8'($urandom_range(0, 255));
			end
		endcase
		return {c[0], c[1], c[2]};
	endfunction

	initial begin
		logic [23:0] pixels[$];
		int          gap;
		pixels = '{
			24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
			24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
			24'hFF0001, 24'hFF0080, 24'h010000, 24'h000001,
			24'h000100, 24'hFFFEFE, 24'h7F80FF, 24'hFE01FF,
			24'h01FE00, 24'hAA55AA, 24'h55AA55, 24'h0102FF,
			24'hFFFFFE, 24'h80FF80
		};
		repeat (N_RANDOM)
			pixels.push_back(rand_pixel());
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (pixels[i]) begin
			gap = ((i / 64) % 4 == 0) ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				pixel_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pixel_valid <= 1'b1;
			{red, green, blue} <= pixels[i];
			do @(posedge clk); while (!pixel_ready);
		end
		pixel_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		int stall;
		int got;
		got = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// one long hold-off so the pipeline fills and backs up to the input
			if (got == HOLD_AT)
				stall = LONG_HOLD;
			else if ((got / 50) % 4 == 1)
				stall = 0;
			else
				stall = $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				hsv_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			hsv_ready <= 1'b1;
			do @(posedge clk); while (!hsv_valid);
			got++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
src/rhsv_pkg.sv
src/rhsv_front.sv
src/rhsv_div.sv
src/rhsv_post.sv
src/rgb_to_hsv_pixel_unit.sv
tb/rgb_to_hsv_pixel_checker.sv
tb/tb_rgb_to_hsv_pixel_unit.sv
